// File: rtl/isb_pkg.sv
// Shared types and constants for the indexed sequence buffer.
// No dependencies; imported by isb_store and indexed_sequence_buffer.
`default_nettype none

package isb_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_POP    = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_READ   = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

`default_nettype wire

// File: rtl/isb_store.sv
// Element storage: one write port, one read port with registered read data.
// Depends on isb_pkg for the data width.
`default_nettype none

module isb_store import isb_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/indexed_sequence_buffer.sv
// Indexed sequence buffer: ordered store of signed 32-bit words with
// push, insert, pop, remove-at, read-at and clear.
// Depends on isb_pkg and isb_store.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request word: action,
//   position, value. Output channel (out_valid/out_ready) returns one result
//   word per request: status, read_value, count (count after the action).
//   One request is in work at a time; in_ready is high only while the
//   sequencer is idle. A finished result sits in an output register, so the
//   next request is taken while that result waits for the receiver.
//   Push, clear, errors, pop, read, insert at the end and remove of the last
//   entry go straight to the done state. Insert at position p shifts the
//   entries from p upward by one slot and then writes the value at p; remove
//   at position p shifts the entries above p down by one slot. Insert and
//   remove move one entry per cycle through the single memory port pair.
//   If the receiver stalls with a result pending, the next request is still
//   processed but holds in its done state until the output register frees.
//   Reset empties the buffer (count 0) and drops any pending result; the
//   storage itself is not cleared.
`default_nettype none

module indexed_sequence_buffer import isb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               action,
  input  wire logic [6:0]               position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      read_value,
  output logic [6:0]                    count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > 7) ? CW : 7;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state;
  logic [CW-1:0]     n;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     stop;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] got;
  logic              mv;
  logic              cap;
  logic              is_ins;
  status_t           res_status;

  logic              accept;
  logic              full;
  logic              empty;
  logic [WW-1:0]     pos_w;
  logic [WW-1:0]     n_w;
  status_t           dec_status;
  logic              dec_we;
  logic              dec_read;
  state_t            dec_next;
  logic [CW-1:0]     n_dec;
  logic              load;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign full     = (n == CW'(CAPACITY));
  assign empty    = (n == '0);
  assign pos_w    = WW'(position);
  assign n_w      = WW'(n);
  assign load     = (state == S_DONE) && (!out_valid || out_ready);

  // request decode, used only in the accept cycle
  always_comb begin
    dec_status = ST_OK;
    dec_we     = 1'b0;
    dec_read   = 1'b0;
    dec_next   = S_DONE;
    n_dec      = n;
    case (action_t'(action))
      ACT_PUSH: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          dec_we = 1'b1;
          n_dec  = n + CW'(1);
        end
      end
      ACT_INSERT: begin
        if (pos_w > n_w) begin
          dec_status = ST_RANGE;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          n_dec = n + CW'(1);
          if (pos_w == n_w) begin
            dec_we = 1'b1;
          end else begin
            dec_next = S_SHIFT;
          end
        end
      end
      ACT_POP: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          dec_read = 1'b1;
          n_dec    = n - CW'(1);
        end
      end
      ACT_REMOVE, ACT_READ: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else if (pos_w >= n_w) begin
          dec_status = ST_RANGE;
        end else begin
          dec_read = 1'b1;
          if (action == ACT_REMOVE) begin
            n_dec = n - CW'(1);
            if ((pos_w + WW'(1)) != n_w) begin
              dec_next = S_SHIFT;
            end
          end
        end
      end
      ACT_CLEAR: begin
        n_dec = '0;
      end
      default: begin
      end
    endcase
  end

  // memory port steering
  always_comb begin
    raddr = cur;
    we    = 1'b0;
    waddr = wa;
    wdata = rdata;
    case (state)
      S_IDLE: begin
        raddr = (action == ACT_POP) ? AW'(n - CW'(1)) : AW'(position);
        if (accept && dec_we) begin
          we    = 1'b1;
          waddr = AW'(n);
          wdata = value;
        end
      end
      S_SHIFT, S_DRAIN: begin
        we = mv;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = val_q;
      end
      default: begin
      end
    endcase
  end

  isb_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      mv        <= 1'b0;
      cap       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cap <= accept & dec_read;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= dec_next;
            n     <= n_dec;
            mv    <= 1'b0;
          end
        end
        S_SHIFT: begin
          mv <= 1'b1;
          if (cur == stop) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          mv    <= 1'b0;
          state <= is_ins ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cap) begin
      got <= rdata;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          got        <= '0;
          res_status <= dec_status;
          is_ins     <= (action == ACT_INSERT);
          pos_q      <= AW'(position);
          val_q      <= value;
          if (action == ACT_INSERT) begin
            cur  <= AW'(n - CW'(1));
            stop <= AW'(position);
          end else begin
            cur  <= AW'(position) + AW'(1);
            stop <= AW'(n - CW'(1));
          end
        end
      end
      S_SHIFT: begin
        // read at cur now, its word lands one slot over next cycle
        wa <= is_ins ? cur + AW'(1) : cur - AW'(1);
        if (cur != stop) begin
          cur <= is_ins ? cur - AW'(1) : cur + AW'(1);
        end
      end
      default: begin
      end
    endcase
    if (load) begin
      status     <= res_status;
      read_value <= cap ? rdata : got;
      count      <= 7'(n);
    end
  end

endmodule

`default_nettype wire
